// ===== src/rlh_pkg.sv =====
// Shared types and constants for the RGB and luma histogram block.
`timescale 1ns / 1ps
`default_nettype none
package rlh_pkg;

  // Command codes
  localparam logic [1:0] CMD_COUNT = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic CFG_SIXTEEN = 1'b0;
  localparam logic CFG_OFFSET  = 1'b1;

  // Histogram channels
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int CH_LUMA  = 3;
  localparam int CHANNELS = 4;

  // Luma weights, sum of weighted samples is shifted down by LUMA_SHIFT
  localparam logic [7:0] LUMA_R = 8'd76;
  localparam logic [7:0] LUMA_G = 8'd150;
  localparam logic [7:0] LUMA_B = 8'd29;
  localparam int LUMA_SHIFT = 8;

  localparam int SAMPLE_W = 16;
  localparam int OFFSET_W = 18;
  localparam int OUT_W    = 32;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [1:0]  read_channel;
    logic [16:0] read_bin;
  } rlh_in_t;

  typedef struct packed {
    logic [31:0] bin_count;
    logic        count_saturated;
  } rlh_out_t;

  // Configuration as seen by the bin calculation
  typedef struct packed {
    logic               sixteen;
    logic signed [17:0] offset;
  } rlh_cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC_A,
    ST_CALC_B,
    ST_FETCH,
    ST_UPDATE,
    ST_REPLY
  } rlh_state_t;

endpackage
`default_nettype wire

// ===== src/rlh_ram.sv =====
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module rlh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 131072
) (
  input  wire logic                     clk,
  input  wire logic                     write_enable,
  input  wire logic [$clog2(DEPTH)-1:0] write_addr,
  input  wire logic [WIDTH-1:0]         write_data,
  input  wire logic [$clog2(DEPTH)-1:0] read_addr,
  output logic      [WIDTH-1:0]         read_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (write_enable) begin
      mem[write_addr] <= write_data;
    end
    read_data <= mem[read_addr];
  end

endmodule
`default_nettype wire

// ===== src/rlh_bin_calc.sv =====
// Two-stage pipeline from raw RGB samples to the four clamped bin indexes.
`timescale 1ns / 1ps
`default_nettype none
module rlh_bin_calc #(
  parameter int BIN_COUNT = 131072
) (
  input  wire logic                                     clk,
  input  wire rlh_pkg::rlh_cfg_t                        cfg,
  input  wire logic [15:0]                              red,
  input  wire logic [15:0]                              green,
  input  wire logic [15:0]                              blue,
  output logic      [3:0][$clog2(BIN_COUNT)-1:0]        bin_addr
);
  import rlh_pkg::*;

  localparam int ABITS = $clog2(BIN_COUNT);
  localparam int SUM_W = SAMPLE_W + 8;
  localparam int V_W   = 20;
  localparam logic signed [V_W-1:0] BIN_LAST = V_W'(BIN_COUNT - 1);

  logic [SAMPLE_W-1:0] wide_r, wide_g, wide_b;
  logic [SAMPLE_W-1:0] s1_r, s1_g, s1_b;
  logic [SUM_W-1:0]    prod_r, prod_g, prod_b;
  logic [SUM_W-1:0]    luma_sum;
  logic [3:0][SAMPLE_W-1:0] value;
  logic [3:0][ABITS-1:0]    addr_next;

  // 8-bit samples repeat the low byte into both halves
  always_comb begin
    wide_r = cfg.sixteen ? red   : {red[7:0], red[7:0]};
    wide_g = cfg.sixteen ? green : {green[7:0], green[7:0]};
    wide_b = cfg.sixteen ? blue  : {blue[7:0], blue[7:0]};
  end

  // Stage 1: widened samples and weighted products
  always_ff @(posedge clk) begin
    s1_r   <= wide_r;
    s1_g   <= wide_g;
    s1_b   <= wide_b;
    prod_r <= SUM_W'(wide_r) * SUM_W'(LUMA_R);
    prod_g <= SUM_W'(wide_g) * SUM_W'(LUMA_G);
    prod_b <= SUM_W'(wide_b) * SUM_W'(LUMA_B);
  end

  // Luma never exceeds 16 bits: the weights sum to 255
  always_comb begin
    luma_sum        = prod_r + prod_g + prod_b;
    value[CH_RED]   = s1_r;
    value[CH_GREEN] = s1_g;
    value[CH_BLUE]  = s1_b;
    value[CH_LUMA]  = luma_sum[LUMA_SHIFT +: SAMPLE_W];
  end

  // Offset and clamp into the bin range
  always_comb begin
    logic signed [V_W-1:0] v;
    v = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      v = $signed({{(V_W-SAMPLE_W){1'b0}}, value[ch]}) + V_W'(cfg.offset);
      if (v < 0) begin
        addr_next[ch] = '0;
      end else if (v > BIN_LAST) begin
        addr_next[ch] = BIN_LAST[ABITS-1:0];
      end else begin
        addr_next[ch] = v[ABITS-1:0];
      end
    end
  end

  // Stage 2: bin indexes
  always_ff @(posedge clk) begin
    bin_addr <= addr_next;
  end

endmodule
`default_nettype wire

// ===== src/rgb_luma_histogram.sv =====
// Four histograms (red, green, blue, luma) over a stream of RGB pixels.
// Count pixel: accepted, then CALC_A, CALC_B, FETCH, UPDATE and REPLY to the result word;
// a new request is taken only once REPLY has loaded the word. Read bin: FETCH, then REPLY.
// Clear: one bin per cycle. The count rate is set by the read, increment, write-back of the
// bin RAMs, one word at a time. Reset: a clearing pass zeroes all bins with req_ready low;
// the configuration registers reset to 8-bit samples and zero offset.
`timescale 1ns / 1ps
`default_nettype none
module rgb_luma_histogram #(
  parameter int BIN_COUNT  = 131072,
  parameter int COUNT_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write_enable,
  input  wire logic              cfg_index,
  input  wire logic [17:0]       cfg_write_data,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire rlh_pkg::rlh_in_t  req,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output rlh_pkg::rlh_out_t      rsp
);
  import rlh_pkg::*;

  localparam int ABITS = $clog2(BIN_COUNT);
  localparam logic [ABITS-1:0] LAST_BIN = ABITS'(BIN_COUNT - 1);

  rlh_state_t state, state_next;
  rlh_cfg_t   cfg;
  rlh_in_t    item;
  logic       item_in_range;
  logic       clear_by_cmd;
  logic [ABITS-1:0] clr_cnt;

  logic [3:0][ABITS-1:0]      calc_addr;
  logic [3:0][ABITS-1:0]      rd_addr;
  logic [3:0][ABITS-1:0]      wr_addr;
  logic [3:0][COUNT_BITS-1:0] rd_data;
  logic [3:0][COUNT_BITS-1:0] wr_data;
  logic                       mem_we;
  logic                       clearing;
  logic                       reply_load;
  logic                       accept;

  logic [COUNT_BITS-1:0]    sel_count;
  logic [COUNT_BITS+31:0]   sel_wide;
  rlh_out_t                 reply;

  assign accept = req_valid && req_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        CFG_SIXTEEN: cfg.sixteen <= cfg_write_data[0];
        CFG_OFFSET:  cfg.offset  <= $signed(cfg_write_data);
        default:     cfg         <= cfg;
      endcase
    end
  end

  // Bin index pipeline
  rlh_bin_calc #(
    .BIN_COUNT(BIN_COUNT)
  ) u_bin_calc (
    .clk     (clk),
    .cfg     (cfg),
    .red     (item.red),
    .green   (item.green),
    .blue    (item.blue),
    .bin_addr(calc_addr)
  );

  // Bin RAMs, one per channel
  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_bins
    always_comb begin
      rd_addr[ch] = (item.command == CMD_READ) ? ABITS'(item.read_bin) : calc_addr[ch];
      wr_addr[ch] = clearing ? clr_cnt : calc_addr[ch];
      if (clearing) begin
        wr_data[ch] = '0;
      end else if (&rd_data[ch]) begin
        wr_data[ch] = rd_data[ch];
      end else begin
        wr_data[ch] = rd_data[ch] + COUNT_BITS'(1);
      end
    end

    rlh_ram #(
      .WIDTH(COUNT_BITS),
      .DEPTH(BIN_COUNT)
    ) u_ram (
      .clk         (clk),
      .write_enable(mem_we),
      .write_addr  (wr_addr[ch]),
      .write_data  (wr_data[ch]),
      .read_addr   (rd_addr[ch]),
      .read_data   (rd_data[ch])
    );
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == LAST_BIN) begin
          state_next = clear_by_cmd ? ST_REPLY : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (req.command)
            CMD_COUNT: state_next = ST_CALC_A;
            CMD_READ:  state_next = ST_FETCH;
            CMD_CLEAR: state_next = ST_CLEAR;
            default:   state_next = ST_REPLY;
          endcase
        end
      end
      ST_CALC_A: state_next = ST_CALC_B;
      ST_CALC_B: state_next = ST_FETCH;
      ST_FETCH:  state_next = (item.command == CMD_READ) ? ST_REPLY : ST_UPDATE;
      ST_UPDATE: state_next = ST_REPLY;
      ST_REPLY: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    req_ready  = 1'b0;
    mem_we     = 1'b0;
    clearing   = 1'b0;
    reply_load = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        clearing = 1'b1;
      end
      ST_IDLE:   req_ready = 1'b1;
      ST_UPDATE: mem_we = 1'b1;
      ST_REPLY:  reply_load = !rsp_valid || rsp_ready;
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  // Read answer: selected count, zero for other commands or an out-of-range bin
  always_comb begin
    sel_count = rd_data[item.read_channel];
    sel_wide  = {32'b0, sel_count};
    reply     = '0;
    if (item.command == CMD_READ && item_in_range) begin
      reply.bin_count       = sel_wide[OUT_W-1:0];
      reply.count_saturated = &sel_count;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      clear_by_cmd <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= (clr_cnt == LAST_BIN) ? '0 : clr_cnt + ABITS'(1);
      end
      if (accept) begin
        clear_by_cmd <= 1'b1;
      end
      if (reply_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Item and result word
  always_ff @(posedge clk) begin
    if (accept) begin
      item          <= req;
      item_in_range <= {2'b00, req.read_bin} < 19'(BIN_COUNT);
    end
    if (reply_load) begin
      rsp <= reply;
    end
  end

endmodule
`default_nettype wire
